### sv/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

    localparam int DEQ_CAPACITY    = 256;
    localparam int DEQ_DATA_WIDTH  = 32;
    localparam int DEQ_WORD_W      = 32;
    localparam int DEQ_COUNT_W     = 9;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } deq_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    typedef struct packed {
        deq_op_t                 op;
        logic [DEQ_WORD_W-1:0]   push_value;
    } deq_in_t;

    typedef struct packed {
        logic [DEQ_WORD_W-1:0]   data_out;
        deq_status_t             status;
        logic [DEQ_COUNT_W-1:0]  entry_count;
    } deq_out_t;

endpackage

### sv/deq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/double_ended_queue.sv
// Top level of the double-ended queue: index control, result register and slot RAM.
//
// A fixed-capacity double-ended queue held as a circular buffer in one RAM of
// CAPACITY words, with a head index (front entry), a tail index (back entry)
// and an entry count. Each input transfer carries one operation (push back,
// push front, pop back, pop front, peek front, peek back) and produces exactly
// one result transfer with the data word concerned, a status (ok, empty, full)
// and the count after the operation. The block takes one operation per clock
// while the result side is not stalled: indices and count update at the input
// transfer edge, the RAM write or read is issued in that same cycle, and the
// result, read words from the RAM's registered port, is offered in the next cycle.
// s_ready is high whenever the result register is empty or its result is
// being taken in the same cycle, so a stream with m_ready held high runs at
// one transfer per clock. A push into a full queue and a pop or peek on an
// empty queue change nothing and report full or empty with a zero data word;
// unused operation codes change nothing and report ok with a zero data word.
// After reset the queue is empty and ready at once; the RAM needs no clearing
// since only held entries are ever read.
module double_ended_queue #(
    parameter int CAPACITY   = deq_pkg::DEQ_CAPACITY,
    parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  deq_pkg::deq_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output deq_pkg::deq_out_t m_data
);

    import deq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Queue state.
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Result register.
    logic                   m_valid_reg;
    deq_status_t            res_status_reg, res_status_next;
    logic [DEQ_COUNT_W-1:0] res_count_reg;
    logic [DEQ_WORD_W-1:0]  res_word_reg, res_word_next;
    logic                   sel_ram_reg, sel_ram_next;

    // RAM port signals.
    logic                  ram_wr, ram_rd;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [DATA_WIDTH-1:0] push_word;

    logic s_xfer;
    logic is_full, is_empty;
    logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Index moves wrap at CAPACITY, which need not be a power of two.
    assign head_inc = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(CAPACITY - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? IDX_W'(CAPACITY - 1) : tail_reg - 1'b1;

    // The stored word keeps DATA_WIDTH bits of the pushed value.
    assign push_word = DATA_WIDTH'(s_data.push_value);

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        ram_wr          = 1'b0;
        ram_rd          = 1'b0;
        ram_waddr       = tail_reg;
        ram_raddr       = head_reg;
        res_status_next = ST_OK;
        res_word_next   = '0;
        sel_ram_next    = 1'b0;
        case (s_data.op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (is_full) begin
                    res_status_next = ST_FULL;
                end else begin
                    if (is_empty) begin
                        // An empty queue restarts with both ends at slot zero.
                        head_next = '0;
                        tail_next = '0;
                        ram_waddr = '0;
                    end else if (s_data.op == OP_PUSH_BACK) begin
                        tail_next = tail_inc;
                        ram_waddr = tail_inc;
                    end else begin
                        head_next = head_dec;
                        ram_waddr = head_dec;
                    end
                    ram_wr        = 1'b1;
                    count_next    = count_reg + 1'b1;
                    res_word_next = DEQ_WORD_W'(push_word);
                end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (is_empty) begin
                    res_status_next = ST_EMPTY;
                end else begin
                    ram_rd       = 1'b1;
                    sel_ram_next = 1'b1;
                    if (s_data.op == OP_POP_BACK || s_data.op == OP_PEEK_BACK) begin
                        ram_raddr = tail_reg;
                    end
                    if (s_data.op == OP_POP_BACK) begin
                        tail_next  = tail_dec;
                        count_next = count_reg - 1'b1;
                    end else if (s_data.op == OP_POP_FRONT) begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (s_xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; the popped or peeked word itself arrives from the RAM's
    // read register, which only moves on an input transfer.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_status_reg <= res_status_next;
            res_count_reg  <= DEQ_COUNT_W'(count_next);
            res_word_reg   <= res_word_next;
            sel_ram_reg    <= sel_ram_next;
        end
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr && s_xfer),
        .wr_addr (ram_waddr),
        .wr_data (push_word),
        .rd_en   (ram_rd && s_xfer),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign m_valid = m_valid_reg;

    always_comb begin
        m_data.data_out    = sel_ram_reg ? DEQ_WORD_W'(ram_rdata) : res_word_reg;
        m_data.status      = res_status_reg;
        m_data.entry_count = res_count_reg;
    end

`ifndef ASSERT_OFF
    // The count can never pass the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A push into a full queue reports full and leaves the count alone.
    a_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && is_full &&
         (s_data.op == OP_PUSH_BACK || s_data.op == OP_PUSH_FRONT))
        |=> (m_data.status == ST_FULL && count_reg == $past(count_reg)))
        else $error("push into full queue not reported as full");

    // A pop or peek on an empty queue reports empty with a zero word.
    a_read_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && is_empty &&
         (s_data.op == OP_POP_BACK || s_data.op == OP_POP_FRONT ||
          s_data.op == OP_PEEK_FRONT || s_data.op == OP_PEEK_BACK))
        |=> (m_data.status == ST_EMPTY && m_data.data_out == '0))
        else $error("read of empty queue not reported as empty");
`endif

endmodule

### bench/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue with randomized traffic and stalls.
`default_nettype none

module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    // Opcodes six and seven have no enum member; the block must ignore them.
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    // Cycles without any transfer on either channel before the run is declared hung.
    // A correct run never idles longer than one input gap plus one result stall
    // plus the read latency, far below this limit.
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 10;
    localparam int SLOT_W        = $clog2(DEQ_CAPACITY);

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    deq_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    deq_out_t m_data;

    double_ended_queue dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the queue. It is advanced once per accepted input
    // transfer, so the outcomes it produces line up with the in-order
    // result stream of the block.
    // ------------------------------------------------------------------
    logic [DEQ_WORD_W-1:0] shadow_slots [DEQ_CAPACITY];
    int shadow_front = 0;
    int shadow_back  = 0;
    int shadow_held  = 0;

    deq_in_t  op_backlog [$];   // operations waiting to be offered to the block
    deq_out_t outcome_q  [$];   // outcomes of accepted operations, oldest first

    int mismatches = 0;
    int idle_cycles = 0;

    // Computes the result of one operation and updates the shadow queue.
    // The front and back indices are inclusive, so an empty queue has no
    // valid slot; the first push after empty pins both ends to slot zero.
    function automatic deq_out_t deque_outcome(deq_in_t item);
        deq_out_t res;
        int slot;
        res = '0;
        res.status = ST_OK;
        case (item.op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (shadow_held >= DEQ_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    if (shadow_held == 0) begin
                        shadow_front = 0;
                        shadow_back  = 0;
                        slot = 0;
                    end else if (item.op == OP_PUSH_BACK) begin
                        shadow_back = (shadow_back + 1) % DEQ_CAPACITY;
                        slot = shadow_back;
                    end else begin
                        shadow_front = (shadow_front + DEQ_CAPACITY - 1) % DEQ_CAPACITY;
                        slot = shadow_front;
                    end
                    shadow_slots[SLOT_W'(slot)] = item.push_value;
                    shadow_held++;
                    res.data_out = item.push_value;
                end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (shadow_held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot = (item.op == OP_POP_BACK || item.op == OP_PEEK_BACK) ?
                           shadow_back : shadow_front;
                    res.data_out = shadow_slots[SLOT_W'(slot)];
                    if (item.op == OP_POP_BACK) begin
                        shadow_back = (shadow_back + DEQ_CAPACITY - 1) % DEQ_CAPACITY;
                        shadow_held--;
                    end else if (item.op == OP_POP_FRONT) begin
                        shadow_front = (shadow_front + 1) % DEQ_CAPACITY;
                        shadow_held--;
                    end
                end
            end
            default: begin
                // Spare opcodes leave everything untouched and report ok.
            end
        endcase
        res.entry_count = DEQ_COUNT_W'(shadow_held);
        return res;
    endfunction

    // Idle pattern shared by both channels: each stretch of transfers is drawn as
    // either back-to-back or one with a random wait before every transfer.
    function automatic int draw_wait(inout int stretch_left, inout bit quiet);
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(20, 120);
            quiet = 1'($urandom_range(0, 1));
        end
        stretch_left--;
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction. The generator keeps its own entry count so
    // that fill and drain phases know when the queue is full or empty.
    // ------------------------------------------------------------------
    int gen_held = 0;
    int gen_random = 0;

    task automatic add_op(logic [2:0] opcode, logic [DEQ_WORD_W-1:0] value, bit counted);
        deq_in_t item;
        item.op = deq_op_t'(opcode);
        item.push_value = value;
        op_backlog.push_back(item);
        case (item.op)
            OP_PUSH_BACK, OP_PUSH_FRONT: if (gen_held < DEQ_CAPACITY) gen_held++;
            OP_POP_BACK, OP_POP_FRONT:   if (gen_held > 0) gen_held--;
            default: ;
        endcase
        if (counted && opcode != OP_SPARE_A && opcode != OP_SPARE_B) begin
            gen_random++;
        end
    endtask

    function automatic logic [DEQ_WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    endfunction

    function automatic logic [2:0] pick_take();
        case ($urandom_range(0, 3))
            0: return OP_POP_BACK;
            1: return OP_POP_FRONT;
            2: return OP_PEEK_FRONT;
            default: return OP_PEEK_BACK;
        endcase
    endfunction

    // Any of the eight opcodes, spare ones only now and then.
    function automatic logic [2:0] pick_any();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        end
        return $urandom_range(0, 1) ? pick_push() : pick_take();
    endfunction

    task automatic build_stimulus();
        int phase;
        int len;
        // Empty queue: every pop and peek reports empty, spare codes do nothing.
        add_op(OP_POP_BACK,   32'h0000_0000, 1'b0);
        add_op(OP_POP_FRONT,  32'hFFFF_FFFF, 1'b0);
        add_op(OP_PEEK_FRONT, 32'h0000_0000, 1'b0);
        add_op(OP_PEEK_BACK,  32'h0000_0000, 1'b0);
        add_op(OP_SPARE_A,    32'hDEAD_BEEF, 1'b0);
        add_op(OP_SPARE_B,    32'hFFFF_FFFF, 1'b0);
        // Push into empty, then both ends, with extreme and alternating words.
        add_op(OP_PUSH_BACK,  32'h0000_0000, 1'b0);
        add_op(OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b0);
        add_op(OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0);
        add_op(OP_PUSH_FRONT, 32'h5555_5555, 1'b0);
        add_op(OP_PEEK_FRONT, 32'h0000_0000, 1'b0);
        add_op(OP_PEEK_BACK,  32'hFFFF_FFFF, 1'b0);
        add_op(OP_SPARE_A,    32'h1234_5678, 1'b0);
        add_op(OP_POP_FRONT,  32'h0000_0000, 1'b0);
        add_op(OP_POP_BACK,   32'h0000_0000, 1'b0);
        add_op(OP_POP_FRONT,  32'h0000_0000, 1'b0);
        add_op(OP_POP_BACK,   32'h0000_0000, 1'b0);
        add_op(OP_POP_FRONT,  32'h0000_0000, 1'b0);
        // A front push into an empty queue also lands on slot zero.
        add_op(OP_PUSH_FRONT, 32'h8000_0001, 1'b0);
        add_op(OP_PEEK_BACK,  32'h0000_0000, 1'b0);
        add_op(OP_POP_BACK,   32'h0000_0000, 1'b0);
        add_op(OP_PEEK_FRONT, 32'h0000_0000, 1'b0);

        // Random phases. The first one always fills the queue so that the
        // full case and index wrap-around are reached in every run.
        phase = 0;
        while (gen_random < RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    // Fill: mostly pushes at either end until full, then
                    // a few pushes that must be rejected.
                    while (gen_held < DEQ_CAPACITY) begin
                        if ($urandom_range(0, 99) < 85) add_op(pick_push(), pick_word(), 1'b1);
                        else add_op(pick_any(), pick_word(), 1'b1);
                    end
                    repeat ($urandom_range(1, 4)) add_op(pick_push(), pick_word(), 1'b1);
                end
                1: begin
                    // Drain: mostly pops and peeks until empty, then a few
                    // more that must report empty.
                    while (gen_held > 0) begin
                        if ($urandom_range(0, 99) < 85) add_op(pick_take(), pick_word(), 1'b1);
                        else add_op(pick_any(), pick_word(), 1'b1);
                    end
                    repeat ($urandom_range(1, 4)) add_op(pick_take(), pick_word(), 1'b1);
                end
                default: begin
                    len = $urandom_range(20, 80);
                    repeat (len) add_op(pick_any(), pick_word(), 1'b1);
                end
            endcase
            phase = $urandom_range(0, 3);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver. A new operation is offered only when the channel is
    // free (nothing offered, or the offered one is taken at this edge) and
    // its drawn wait has run out; an offered operation is held unchanged.
    // ------------------------------------------------------------------
    int  src_wait = 0;
    int  src_stretch = 0;
    bit  src_quiet = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                outcome_q.push_back(deque_outcome(s_data));
            end
            if (!s_valid || s_ready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_valid <= 1'b0;
                end else if (op_backlog.size() > 0) begin
                    s_data  <= op_backlog.pop_front();
                    s_valid <= 1'b1;
                    src_wait = draw_wait(src_stretch, src_quiet);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Every result transfer is checked field by field
    // against the oldest outstanding outcome. m_ready is dropped for a
    // drawn number of cycles after each result transfer.
    // ------------------------------------------------------------------
    int  sink_wait = 0;
    int  sink_stretch = 0;
    bit  sink_quiet = 1'b0;

    always @(posedge aclk) begin
        deq_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] unexpected result: data %h status %0d count %0d",
                                 $realtime, m_data.data_out, m_data.status,
                                 m_data.entry_count);
                    end
                end else begin
                    want = outcome_q.pop_front();
                    if (m_data.data_out !== want.data_out || m_data.status !== want.status ||
                        m_data.entry_count !== want.entry_count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("[%0t] mismatch: expected data %h status %0d count %0d,",
                                     $realtime, want.data_out, want.status,
                                     want.entry_count);
                            $display("           got data %h status %0d count %0d",
                                     m_data.data_out, m_data.status, m_data.entry_count);
                        end
                    end
                end
                sink_wait = draw_wait(sink_stretch, sink_quiet);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_ready <= (sink_wait == 0);
        end
    end

    // Watchdog: a run in which no transfer happens for too long is hung.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Main sequence: build the stimulus, reset once, then wait for every
    // operation to be accepted and every outcome to be matched.
    initial begin
        build_stimulus();
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // Sampled on the falling edge so the driver and monitor have settled.
        do @(negedge aclk);
        while (op_backlog.size() > 0 || s_valid || outcome_q.size() > 0);
        // Give a stray extra result time to show up.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
sv/deq_pkg.sv
sv/deq_ram.sv
sv/double_ended_queue.sv
bench/tb_double_ended_queue.sv
